/* src/morse_character_keyer_assert.svh */
// Assertion macros shared by the keyer modules.
`ifndef MORSE_CHARACTER_KEYER_ASSERT_SVH
`define MORSE_CHARACTER_KEYER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define MCK_ASSERT_NOW(label, clk, rst, cond, conseq) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
    else $error("keyer assertion failed");

// Next-cycle implication, disabled during reset.
`define MCK_ASSERT_NEXT(label, clk, rst, cond, conseq) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error("keyer assertion failed");

`endif

/* src/mck_pkg.sv */
// Shared constants, types and the Morse code table of the keyer.
`default_nettype none

package mck_pkg;

  localparam int CODE_W               = 8;
  localparam int MAX_ELEMENTS_DEFAULT = 6;
  localparam int QUEUE_DEPTH          = 2;
  localparam int DOT_W                = 16;
  localparam int ON_W                 = 18;
  localparam int OFF_W                = 19;
  localparam logic [DOT_W-1:0] DOT_TIME_RESET = 16'd100;
  localparam logic ELEM_DASH          = 1'b1;

  // Pattern holds the elements in sending order from bit len-1 down to bit 0.
  typedef struct packed {
    logic [3:0]        len;
    logic [CODE_W-1:0] pat;
  } code_t;

  function automatic code_t code_lookup(input logic [7:0] ch);
    code_t      c;
    logic [7:0] u;
    u = ch;
    if (ch >= "a" && ch <= "z") begin
      u = ch - 8'd32;
    end
    case (u)
      "!":  c = '{4'd6, 8'b101011};
      "\"": c = '{4'd6, 8'b010010};
      "'":  c = '{4'd6, 8'b011110};
      "(":  c = '{4'd5, 8'b10110};
      ")":  c = '{4'd6, 8'b101101};
      "+":  c = '{4'd5, 8'b01010};
      ",":  c = '{4'd6, 8'b110011};
      "-":  c = '{4'd6, 8'b100001};
      ".":  c = '{4'd6, 8'b010101};
      "/":  c = '{4'd5, 8'b10010};
      "0":  c = '{4'd5, 8'b11111};
      "1":  c = '{4'd5, 8'b01111};
      "2":  c = '{4'd5, 8'b00111};
      "3":  c = '{4'd5, 8'b00011};
      "4":  c = '{4'd5, 8'b00001};
      "5":  c = '{4'd5, 8'b00000};
      "6":  c = '{4'd5, 8'b10000};
      "7":  c = '{4'd5, 8'b11000};
      "8":  c = '{4'd5, 8'b11100};
      "9":  c = '{4'd5, 8'b11110};
      ":":  c = '{4'd6, 8'b111000};
      ";":  c = '{4'd6, 8'b101010};
      "=":  c = '{4'd5, 8'b10001};
      "?":  c = '{4'd6, 8'b001100};
      "@":  c = '{4'd6, 8'b011010};
      "_":  c = '{4'd6, 8'b001101};
      "A":  c = '{4'd2, 8'b01};
      "B":  c = '{4'd4, 8'b1000};
      "C":  c = '{4'd4, 8'b1010};
      "D":  c = '{4'd3, 8'b100};
      "E":  c = '{4'd1, 8'b0};
      "F":  c = '{4'd4, 8'b0010};
      "G":  c = '{4'd3, 8'b110};
      "H":  c = '{4'd4, 8'b0000};
      "I":  c = '{4'd2, 8'b00};
      "J":  c = '{4'd4, 8'b0111};
      "K":  c = '{4'd3, 8'b101};
      "L":  c = '{4'd4, 8'b0100};
      "M":  c = '{4'd2, 8'b11};
      "N":  c = '{4'd2, 8'b10};
      "O":  c = '{4'd3, 8'b111};
      "P":  c = '{4'd4, 8'b0110};
      "Q":  c = '{4'd4, 8'b1101};
      "R":  c = '{4'd3, 8'b010};
      "S":  c = '{4'd3, 8'b000};
      "T":  c = '{4'd1, 8'b1};
      "U":  c = '{4'd3, 8'b001};
      "V":  c = '{4'd4, 8'b0001};
      "W":  c = '{4'd3, 8'b011};
      "X":  c = '{4'd4, 8'b1001};
      "Y":  c = '{4'd4, 8'b1011};
      "Z":  c = '{4'd4, 8'b1100};
      default: c = '{4'd0, 8'd0};
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

/* src/mck_front.sv */
// Front end: classify a character and pack its code into a queue entry.
`default_nettype none

module mck_front #(
  parameter int MAX_ELEMENTS = mck_pkg::MAX_ELEMENTS_DEFAULT,
  parameter int LEN_W        = $clog2(MAX_ELEMENTS + 1),
  parameter int ENTRY_W      = MAX_ELEMENTS + LEN_W + 1
) (
  input  wire logic [7:0]         character,
  input  wire logic               end_of_text,
  output logic      [ENTRY_W-1:0] entry
);

  mck_pkg::code_t   code;
  logic [LEN_W-1:0] len;

  always_comb begin
    code = mck_pkg::code_lookup(character);
    // clip to the element budget
    if (code.len > 4'(MAX_ELEMENTS)) begin
      len = LEN_W'(MAX_ELEMENTS);
    end else begin
      len = LEN_W'(code.len);
    end
  end

  assign entry = {end_of_text, len, code.pat[MAX_ELEMENTS-1:0]};

endmodule

`default_nettype wire

/* src/mck_queue.sv */
// Short item queue between the front end and the element sequencer.
`default_nettype none

`include "morse_character_keyer_assert.svh"

module mck_queue #(
  parameter int W     = 10,
  parameter int DEPTH = mck_pkg::QUEUE_DEPTH
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  input  wire logic [W-1:0] din,
  input  wire logic         pop,
  output logic      [W-1:0] head,
  output logic              nonempty,
  output logic              full
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign nonempty = (count != '0);
  assign full     = (count == CNT_W'(DEPTH));
  assign head     = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `MCK_ASSERT_NOW(a_no_push_when_full, clk, rst, full, !push || pop)
  `MCK_ASSERT_NOW(a_no_pop_when_empty, clk, rst, pop, nonempty)

endmodule

`default_nettype wire

/* src/mck_back.sv */
// Element sequencer: expand the queue head into one result per cycle.
`default_nettype none

`include "morse_character_keyer_assert.svh"

module mck_back #(
  parameter int MAX_ELEMENTS = mck_pkg::MAX_ELEMENTS_DEFAULT,
  parameter int LEN_W        = $clog2(MAX_ELEMENTS + 1),
  parameter int ENTRY_W      = MAX_ELEMENTS + LEN_W + 1
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic [mck_pkg::DOT_W-1:0]  dot_time,
  input  wire logic [ENTRY_W-1:0]         head,
  input  wire logic                       head_valid,
  output logic                            pop,
  output logic                            result_strobe,
  output logic      [mck_pkg::ON_W-1:0]   on_time,
  output logic      [mck_pkg::OFF_W-1:0]  off_time,
  output logic                            has_code,
  output logic                            last
);

  localparam int IDX_W = $clog2(MAX_ELEMENTS);

  logic [MAX_ELEMENTS-1:0]  pat;
  logic [LEN_W-1:0]         len;
  logic                     eot;
  logic [IDX_W-1:0]         pos;
  logic [IDX_W-1:0]         pos_next;
  logic [LEN_W-1:0]         bit_idx;
  logic                     is_last;
  logic                     coded;
  logic                     dash;
  logic [mck_pkg::ON_W-1:0]  d1;
  logic [mck_pkg::ON_W-1:0]  d3;
  logic [mck_pkg::OFF_W-1:0] d2;
  logic [mck_pkg::OFF_W-1:0] d4;
  logic [mck_pkg::OFF_W-1:0] d5;
  logic [mck_pkg::ON_W-1:0]  on_next;
  logic [mck_pkg::OFF_W-1:0] off_next;

  assign {eot, len, pat} = head;

  always_comb begin
    coded   = (len != '0);
    is_last = !coded || ((LEN_W'(pos) + LEN_W'(1)) == len);
    bit_idx = len - LEN_W'(1) - LEN_W'(pos);
    dash    = (pat[bit_idx[IDX_W-1:0]] == mck_pkg::ELEM_DASH);
    pop     = head_valid && is_last;
    if (!head_valid) begin
      pos_next = pos;
    end else if (is_last) begin
      pos_next = '0;
    end else begin
      pos_next = pos + 1'b1;
    end

    d1 = mck_pkg::ON_W'(dot_time);
    d3 = d1 + {d1[mck_pkg::ON_W-2:0], 1'b0};
    d2 = {2'b0, dot_time, 1'b0};
    d4 = {1'b0, dot_time, 2'b0};
    d5 = d4 + mck_pkg::OFF_W'(dot_time);

    if (!coded) begin
      on_next  = '0;
      off_next = eot ? d4 : d2;
    end else begin
      on_next = dash ? d3 : d1;
      if (is_last) begin
        off_next = eot ? d5 : mck_pkg::OFF_W'(d3);
      end else begin
        off_next = mck_pkg::OFF_W'(d1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos           <= '0;
      result_strobe <= 1'b0;
    end else begin
      pos           <= pos_next;
      result_strobe <= head_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (head_valid) begin
      on_time  <= on_next;
      off_time <= off_next;
      has_code <= coded;
      last     <= is_last;
    end
  end

  `MCK_ASSERT_NOW(a_nocode_single, clk, rst, result_strobe && !has_code, last && on_time == '0)
  `MCK_ASSERT_NEXT(a_elements_contiguous, clk, rst, result_strobe && !last, result_strobe)
  `MCK_ASSERT_NEXT(a_pos_restarts, clk, rst, pop, pos == '0)

endmodule

`default_nettype wire

/* src/morse_character_keyer.sv */
// Top level of the Morse character keyer.
// An accepted character passes the item queue, then the sequencer's result registers.
// Throughput: the sequencer emits one element result per cycle, so a character
//   yields 1 to 6 results (one per dot or dash, one for a character without code).
// start is taken whenever the two-entry item queue has room (busy low).
// Reset (synchronous): dot_time returns to 100, the queue empties, no result is pending.
`default_nettype none

module morse_character_keyer #(
  parameter int MAX_ELEMENTS = mck_pkg::MAX_ELEMENTS_DEFAULT
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  // configuration: dot length
  input  wire logic                       cfg_we,
  input  wire logic [mck_pkg::DOT_W-1:0]  cfg_data,
  // item in
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic [7:0]                 character,
  input  wire logic                       end_of_text,
  // results out, one element per strobe
  output logic                            result_strobe,
  output logic      [mck_pkg::ON_W-1:0]   on_time,
  output logic      [mck_pkg::OFF_W-1:0]  off_time,
  output logic                            has_code,
  output logic                            last
);

  localparam int LEN_W   = $clog2(MAX_ELEMENTS + 1);
  localparam int ENTRY_W = MAX_ELEMENTS + LEN_W + 1;

  logic [mck_pkg::DOT_W-1:0] dot_time;
  logic [ENTRY_W-1:0]        new_entry;
  logic [ENTRY_W-1:0]        head;
  logic                      head_valid;
  logic                      q_full;
  logic                      pop;
  logic                      push;

  // Hold the dot length; the user must change it only while the keyer is idle (the
  // block does not enforce this), so the sequencer may read it directly.
  always_ff @(posedge clk) begin
    if (rst) begin
      dot_time <= mck_pkg::DOT_TIME_RESET;
    end else if (cfg_we) begin
      dot_time <= cfg_data;
    end
  end

  // Accept a character whenever the queue has a free slot.
  assign busy = q_full;
  assign push = start && !busy;

  // Classify the character: case fold, table lookup, element count.
  mck_front #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .LEN_W        (LEN_W),
    .ENTRY_W      (ENTRY_W)
  ) u_front (
    .character   (character),
    .end_of_text (end_of_text),
    .entry       (new_entry)
  );

  // Decouple acceptance from element output.
  mck_queue #(
    .W     (ENTRY_W),
    .DEPTH (mck_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .din      (new_entry),
    .pop      (pop),
    .head     (head),
    .nonempty (head_valid),
    .full     (q_full)
  );

  // Walk the elements of the head item, one registered result a cycle;
  // drop the item from the queue with its last element.
  mck_back #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .LEN_W        (LEN_W),
    .ENTRY_W      (ENTRY_W)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .dot_time      (dot_time),
    .head          (head),
    .head_valid    (head_valid),
    .pop           (pop),
    .result_strobe (result_strobe),
    .on_time       (on_time),
    .off_time      (off_time),
    .has_code      (has_code),
    .last          (last)
  );

endmodule

`default_nettype wire

/* test/morse_character_keyer_test.sv */
// Self-checking testbench for the Morse character keyer: directed and random characters.
`timescale 1ns / 100ps

module morse_character_keyer_test;

  // Bound the drain after each phase, and then let the pipeline empty.
  localparam int DRAIN_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 6;
  localparam int REPORT_LIMIT  = 10;

  // One element of a keyed character, as it should appear on the result ports.
  typedef struct {
    logic [mck_pkg::ON_W-1:0]  on_time;
    logic [mck_pkg::OFF_W-1:0] off_time;
    logic                      has_code;
    logic                      last;
  } key_elem_t;

  logic                      clk = 1'b0;
  logic                      rst;
  logic                      cfg_we;
  logic [mck_pkg::DOT_W-1:0] cfg_data;
  logic                      start;
  logic                      busy;
  logic [7:0]                character;
  logic                      end_of_text;
  logic                      result_strobe;
  logic [mck_pkg::ON_W-1:0]  on_time;
  logic [mck_pkg::OFF_W-1:0] off_time;
  logic                      has_code;
  logic                      last;

  // Elements still owed by the keyer, oldest first.
  key_elem_t                 pending_elements[$];
  // Our own copy of the dot length register.
  logic [mck_pkg::DOT_W-1:0] dot_len;
  int                        mismatches = 0;
  // Chance, in percent, that the sender holds off before an item.
  int                        sender_gap_pct = 0;

  morse_character_keyer i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .start        (start),
    .busy         (busy),
    .character    (character),
    .end_of_text  (end_of_text),
    .result_strobe(result_strobe),
    .on_time      (on_time),
    .off_time     (off_time),
    .has_code     (has_code),
    .last         (last)
  );

  always #2 clk = ~clk;

  // Hard stop in case the keyer hangs on the handshake or never drains.
  initial begin
    #1_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Count a failure; only the first few get a full report.
  task automatic note_mismatch(input string what);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) begin
      $display("%0t ns: %s", $realtime, what);
    end
  endtask

  // Dots and dashes of a character, in sending order. Lower case folds to upper case;
  // anything not listed has no code and yields an empty string.
  function automatic string morse_of(input logic [7:0] ch);
    logic [7:0] u;
    u = (ch >= "a" && ch <= "z") ? ch - 8'd32 : ch;
    case (u)
      "!": return "-.-.--";   "\"": return ".-..-.";  "'": return ".----.";
      "(": return "-.--.";    ")": return "-.--.-";   "+": return ".-.-.";
      ",": return "--..--";   "-": return "-....-";   ".": return ".-.-.-";
      "/": return "-..-.";
      "0": return "-----";    "1": return ".----";    "2": return "..---";
      "3": return "...--";    "4": return "....-";    "5": return ".....";
      "6": return "-....";    "7": return "--...";    "8": return "---..";
      "9": return "----.";
      ":": return "---...";   ";": return "-.-.-.";   "=": return "-...-";
      "?": return "..--..";   "@": return ".--.-.";   "_": return "..--.-";
      "A": return ".-";   "B": return "-...";  "C": return "-.-.";  "D": return "-..";
      "E": return ".";    "F": return "..-.";  "G": return "--.";   "H": return "....";
      "I": return "..";   "J": return ".---";  "K": return "-.-";   "L": return ".-..";
      "M": return "--";   "N": return "-.";    "O": return "---";   "P": return ".--.";
      "Q": return "--.-"; "R": return ".-.";   "S": return "...";   "T": return "-";
      "U": return "..-";  "V": return "...-";  "W": return ".--";   "X": return "-..-";
      "Y": return "-.--"; "Z": return "--..";
      default: return "";
    endcase
  endfunction

  // Work out the elements one accepted character must produce and queue them up.
  task automatic predict_elements(input logic [7:0] ch, input logic eot);
    string       code;
    int          n;
    logic [31:0] d;
    logic [31:0] on_v;
    logic [31:0] off_v;
    key_elem_t   e;
    code = morse_of(ch);
    n    = code.len();
    d    = {16'd0, dot_len};
    if (n == 0) begin
      // No code: a single silent element carrying the inter-character gap.
      e.on_time  = '0;
      off_v      = eot ? 4 * d : 2 * d;
      e.off_time = off_v[mck_pkg::OFF_W-1:0];
      e.has_code = 1'b0;
      e.last     = 1'b1;
      pending_elements.push_back(e);
    end else begin
      for (int k = 0; k < n; k++) begin
        on_v = (code[k] == "-") ? 3 * d : d;
        // Stretch the gap after the final element; lengthen it further at end of text.
        off_v = (k == n - 1) ? (eot ? 5 * d : 3 * d) : d;
        e.on_time  = on_v[mck_pkg::ON_W-1:0];
        e.off_time = off_v[mck_pkg::OFF_W-1:0];
        e.has_code = 1'b1;
        e.last     = (k == n - 1);
        pending_elements.push_back(e);
      end
    end
  endtask

  // Present one character and hold it until the keyer takes it. Leave start high on return
  // so that back-to-back items need no second assignment in the same step.
  task automatic key_character(input logic [7:0] ch, input logic eot);
    if ($urandom_range(0, 99) < sender_gap_pct) begin
      start       <= 1'b0;
      character   <= 8'($urandom);
      end_of_text <= 1'($urandom);
      do @(posedge clk); while ($urandom_range(0, 99) < sender_gap_pct);
    end
    start       <= 1'b1;
    character   <= ch;
    end_of_text <= eot;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_elements(ch, eot);
  endtask

  // Drop start and wait until every owed element has come out, then let the pipeline settle.
  task automatic await_quiet();
    int waited;
    waited = 0;
    start <= 1'b0;
    while (pending_elements.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (pending_elements.size() != 0) begin
      note_mismatch($sformatf("%0d elements never arrived", pending_elements.size()));
      pending_elements.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Change the dot length only once the keyer is idle.
  task automatic set_dot_len(input logic [mck_pkg::DOT_W-1:0] value);
    await_quiet();
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we   <= 1'b0;
    dot_len = value;
  endtask

  // Mostly characters with a code in either case, the rest anywhere in the 8-bit range.
  function automatic logic [7:0] pick_character();
    string punct;
    int    sel;
    punct = "!\"'()+,-./:;=?@_";
    sel   = $urandom_range(0, 99);
    if (sel < 20) begin
      return 8'("A" + $urandom_range(0, 25));
    end else if (sel < 40) begin
      return 8'("a" + $urandom_range(0, 25));
    end else if (sel < 55) begin
      return 8'("0" + $urandom_range(0, 9));
    end else if (sel < 75) begin
      return punct[$urandom_range(0, punct.len() - 1)];
    end
    return 8'($urandom_range(0, 255));
  endfunction

  // Compare each element against the oldest one owed; the receiver cannot stall, so
  // take every strobe as it comes.
  always @(posedge clk) begin
    key_elem_t e;
    if (!rst && result_strobe) begin
      if (pending_elements.size() == 0) begin
        note_mismatch($sformatf("unexpected element on=%0d off=%0d code=%0b last=%0b",
                                on_time, off_time, has_code, last));
      end else begin
        e = pending_elements.pop_front();
        if (on_time !== e.on_time || off_time !== e.off_time ||
            has_code !== e.has_code || last !== e.last) begin
          note_mismatch($sformatf(
            {"element mismatch: expected on=%0d off=%0d code=%0b last=%0b, ",
             "got on=%0d off=%0d code=%0b last=%0b"},
            e.on_time, e.off_time, e.has_code, e.last, on_time, off_time, has_code, last));
        end
      end
    end
  end

  // Reset value of the dot length, every kind of character and both ends of the code range.
  task automatic test_directed_characters();
    sender_gap_pct = 7;
    // Keep the reset dot length for the first batch.
    key_character("E", 1'b0);
    key_character("T", 1'b1);
    key_character("a", 1'b0);
    key_character("Z", 1'b0);
    key_character("0", 1'b1);
    key_character("!", 1'b0);
    key_character("@", 1'b1);
    key_character(8'd0, 1'b0);
    key_character(8'd0, 1'b1);
    key_character(8'd255, 1'b1);
    key_character(8'd128, 1'b0);
    key_character(8'd127, 1'b0);
    key_character(" ", 1'b0);
    // Longest dot: all-dash digit and the widest gap without a code.
    set_dot_len(16'hFFFF);
    key_character("0", 1'b1);
    key_character(8'd200, 1'b1);
    key_character("5", 1'b0);
    key_character("_", 1'b1);
    // Shortest nonzero dot.
    set_dot_len(16'd1);
    key_character("h", 1'b0);
    key_character("?", 1'b1);
    key_character("#", 1'b1);
    // Zero dot length: elements still come out, every time reads zero.
    set_dot_len(16'd0);
    key_character("q", 1'b0);
    key_character("7", 1'b1);
    key_character(8'd1, 1'b1);
  endtask

  // Random text at one sender idling rate, first at a random dot length, then at an extreme.
  task automatic test_random_text(input int gap_pct,
                                  input logic [mck_pkg::DOT_W-1:0] extreme_dot,
                                  input int items_per_setting);
    sender_gap_pct = gap_pct;
    set_dot_len(16'($urandom_range(2, 65534)));
    repeat (items_per_setting) key_character(pick_character(), $urandom_range(0, 3) == 0);
    set_dot_len(extreme_dot);
    repeat (items_per_setting) key_character(pick_character(), $urandom_range(0, 3) == 0);
  endtask

  initial begin
    rst         <= 1'b1;
    cfg_we      <= 1'b0;
    cfg_data    <= '0;
    start       <= 1'b0;
    character   <= '0;
    end_of_text <= 1'b0;
    dot_len = mck_pkg::DOT_TIME_RESET;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_characters();
    test_random_text(7, 16'd1, 48);
    test_random_text(65, 16'hFFFF, 48);
    test_random_text(0, 16'($urandom_range(1, 8)), 48);

    await_quiet();
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
